// ----- hdl/hs_pkg.sv -----
`default_nettype none

package hs_pkg;

  // Default sizes of the generator.
  localparam int HS_MAX_DIMS   = 8;
  localparam int HS_INDEX_BITS = 20;
  localparam int HS_FRAC_BITS  = 24;

  // Number of primes in the base table and the widths that follow from it.
  localparam int HS_PRIME_COUNT = 12;
  localparam int HS_BASE_W      = 6;  // largest base is 37
  localparam int HS_LOG_W       = 3;  // floor(log2) of the largest base is 5
  localparam int HS_DIM_W       = 4;  // dimension counter, up to the prime count
  localparam int HS_DIM_OUT_W   = 3;  // dimension field on the result ports
  localparam int HS_CFG_W       = 4;  // width of the dimension count register

  // Reset value of the dimension count register.
  localparam logic [HS_CFG_W-1:0] HS_NUM_DIMS_RST = 4'd2;

  // Prime base of dimension j.
  function automatic logic [HS_BASE_W-1:0] hs_base(input logic [HS_DIM_W-1:0] j);
    logic [HS_BASE_W-1:0] b;
    case (j)
      4'd0:    b = 6'd2;
      4'd1:    b = 6'd3;
      4'd2:    b = 6'd5;
      4'd3:    b = 6'd7;
      4'd4:    b = 6'd11;
      4'd5:    b = 6'd13;
      4'd6:    b = 6'd17;
      4'd7:    b = 6'd19;
      4'd8:    b = 6'd23;
      4'd9:    b = 6'd29;
      4'd10:   b = 6'd31;
      4'd11:   b = 6'd37;
      default: b = 6'd2;
    endcase
    return b;
  endfunction

  // floor(log2) of the prime base of dimension j. Dividing by the base
  // shortens the remaining index by at least this many bits.
  function automatic logic [HS_LOG_W-1:0] hs_base_log(input logic [HS_DIM_W-1:0] j);
    logic [HS_LOG_W-1:0] l;
    case (j)
      4'd0:    l = 3'd1;
      4'd1:    l = 3'd1;
      4'd2:    l = 3'd2;
      4'd3:    l = 3'd2;
      4'd4:    l = 3'd3;
      4'd5:    l = 3'd3;
      4'd6:    l = 3'd4;
      4'd7:    l = 3'd4;
      4'd8:    l = 3'd4;
      4'd9:    l = 3'd4;
      4'd10:   l = 3'd4;
      4'd11:   l = 3'd5;
      default: l = 3'd1;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/halton_sequence_generator_core.sv -----
`default_nettype none

// Halton point generator. A start pulse with busy low takes one sample index;
// the core then gives one coordinate per active dimension, in dimension
// order, each as a floor(rev * 2^FRAC_BITS / p^k) fraction, with last set on
// the final one. Each result is on the result ports for exactly one cycle
// with valid_o high, and the receiver cannot stall the core: it must take
// every result in the cycle it appears. One compare-subtract unit does the
// division and scaling one bit per cycle. For dimension j with base p, the
// digit steps work on the remaining index length L, starting at INDEX_BITS
// and dropping by floor(log2 p) per digit. Index zero skips the digit
// steps and goes straight to scaling. The dimension count register may be
// written at any time; the value in it when an item is taken applies to
// that whole item.
module halton_sequence_generator_core #(
  parameter int MAX_DIMS   = hs_pkg::HS_MAX_DIMS,
  parameter int INDEX_BITS = hs_pkg::HS_INDEX_BITS,
  parameter int FRAC_BITS  = hs_pkg::HS_FRAC_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [INDEX_BITS-1:0]                  sample_index_i,
  input  logic                                   cfg_we_i,
  input  logic [hs_pkg::HS_CFG_W-1:0]            cfg_wdata_i,
  output logic                                   valid_o,
  output logic [hs_pkg::HS_DIM_OUT_W-1:0]        dimension_o,
  output logic [FRAC_BITS-1:0]                   coordinate_o,
  output logic                                   last_o
);

  import hs_pkg::*;

  // p^k stays below 37 * 2^INDEX_BITS, so it fits in INDEX_BITS + 6 bits.
  localparam int PKW     = INDEX_BITS + HS_BASE_W;
  localparam int UW      = PKW + 1;
  localparam int CNT_MAX = (INDEX_BITS > FRAC_BITS) ? INDEX_BITS : FRAC_BITS;
  localparam int CW      = $clog2(CNT_MAX + 1);
  localparam int TLW     = $clog2(INDEX_BITS + 1);
  localparam int TIW     = $clog2(INDEX_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_CHECK,
    ST_DIV,
    ST_UPD,
    ST_SCALE
  } state_e;

  state_e                 state_q;
  logic [HS_CFG_W-1:0]    num_dims_q;
  logic [HS_DIM_W-1:0]    n_q;
  logic [HS_DIM_W-1:0]    dim_q;
  logic [INDEX_BITS-1:0]  idx_q;
  logic [INDEX_BITS-1:0]  t_q;
  logic [INDEX_BITS-1:0]  quo_q;
  logic [HS_BASE_W-1:0]   r_q;
  logic [PKW-1:0]         rev_q;
  logic [PKW-1:0]         pk_q;
  logic [PKW-1:0]         rem_q;
  logic [FRAC_BITS-1:0]   q_q;
  logic [HS_BASE_W-1:0]   base_q;
  logic [HS_LOG_W-1:0]    lg_q;
  logic [TLW-1:0]         tlen_q;
  logic [CW-1:0]          cnt_q;
  logic                   valid_q;
  logic [HS_DIM_OUT_W-1:0] dimension_q;
  logic [FRAC_BITS-1:0]   coordinate_q;
  logic                   last_q;

  logic [HS_DIM_W-1:0]    n_req;
  logic [CW-1:0]          cnt_m1;
  logic                   t_bit;
  logic [UW-1:0]          unit_a;
  logic [UW-1:0]          unit_b;
  logic                   unit_ge;
  logic [UW-1:0]          unit_diff;
  logic [PKW+HS_BASE_W-1:0] rev_prod;
  logic [PKW+HS_BASE_W-1:0] pk_prod;
  logic                   is_last;

  // Dimension count for a new item: zero means one, above the limit saturates.
  always_comb begin
    n_req = (num_dims_q == '0) ? HS_DIM_W'(1) : HS_DIM_W'(num_dims_q);
    if (n_req > HS_DIM_W'(MAX_DIMS)) begin
      n_req = HS_DIM_W'(MAX_DIMS);
    end
  end

  // Next index bit to bring down during digit extraction.
  assign cnt_m1 = cnt_q - CW'(1);
  assign t_bit  = t_q[cnt_m1[TIW-1:0]];

  // The shared unit divides the index by the base during digit extraction and
  // the mirrored value by p^k during final scaling.
  always_comb begin
    case (state_q)
      ST_DIV: begin
        unit_a = {{(UW-HS_BASE_W-1){1'b0}}, r_q, t_bit};
        unit_b = {{(UW-HS_BASE_W){1'b0}}, base_q};
      end
      ST_SCALE: begin
        unit_a = {rem_q, 1'b0};
        unit_b = {1'b0, pk_q};
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  hs_step_unit #(
    .W (UW)
  ) u_step (
    .a_i    (unit_a),
    .b_i    (unit_b),
    .ge_o   (unit_ge),
    .diff_o (unit_diff)
  );

  // Digit append and power update; both values stay below PKW bits.
  assign rev_prod = (PKW+HS_BASE_W)'(rev_q) * (PKW+HS_BASE_W)'(base_q);
  assign pk_prod  = (PKW+HS_BASE_W)'(pk_q) * (PKW+HS_BASE_W)'(base_q);

  assign is_last = (dim_q == n_q - HS_DIM_W'(1));

  // Dimension count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= HS_NUM_DIMS_RST;
    end else if (cfg_we_i) begin
      num_dims_q <= cfg_wdata_i;
    end
  end

  // Sequencer with its datapath registers and the result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      dim_q   <= '0;
      n_q     <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            idx_q   <= sample_index_i;
            n_q     <= n_req;
            dim_q   <= '0;
            state_q <= ST_INIT;
          end
        end
        ST_INIT: begin
          t_q     <= idx_q;
          rev_q   <= '0;
          pk_q    <= PKW'(1);
          tlen_q  <= TLW'(INDEX_BITS);
          base_q  <= hs_base(dim_q);
          lg_q    <= hs_base_log(dim_q);
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (t_q == '0) begin
            rem_q   <= rev_q;
            q_q     <= '0;
            cnt_q   <= CW'(FRAC_BITS);
            state_q <= ST_SCALE;
          end else begin
            r_q     <= '0;
            quo_q   <= '0;
            cnt_q   <= CW'(tlen_q);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          r_q   <= unit_diff[HS_BASE_W-1:0];
          quo_q <= {quo_q[INDEX_BITS-2:0], unit_ge};
          cnt_q <= cnt_m1;
          if (cnt_q == CW'(1)) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          rev_q <= rev_prod[PKW-1:0] + PKW'(r_q);
          pk_q  <= pk_prod[PKW-1:0];
          t_q   <= quo_q;
          if (tlen_q > TLW'(lg_q)) begin
            tlen_q <= tlen_q - TLW'(lg_q);
          end else begin
            tlen_q <= '0;
          end
          state_q <= ST_CHECK;
        end
        ST_SCALE: begin
          rem_q <= unit_diff[PKW-1:0];
          q_q   <= {q_q[FRAC_BITS-2:0], unit_ge};
          cnt_q <= cnt_m1;
          if (cnt_q == CW'(1)) begin
            valid_q      <= 1'b1;
            dimension_q  <= dim_q[HS_DIM_OUT_W-1:0];
            coordinate_q <= {q_q[FRAC_BITS-2:0], unit_ge};
            last_q       <= is_last;
            if (is_last) begin
              state_q <= ST_IDLE;
            end else begin
              dim_q   <= dim_q + HS_DIM_W'(1);
              state_q <= ST_INIT;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign valid_o      = valid_q;
  assign dimension_o  = dimension_q;
  assign coordinate_o = coordinate_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ----- hdl/hs_step_unit.sv -----
`default_nettype none

// One restoring division step: compare the partial remainder against the
// divisor and give the reduced value when it fits.
module hs_step_unit #(
  parameter int W = 27
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic         ge_o,
  output logic [W-1:0] diff_o
);

  logic [W:0] sub;

  // The borrow out of the subtraction tells whether the divisor fits.
  assign sub    = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o   = ~sub[W];
  assign diff_o = ge_o ? sub[W-1:0] : a_i;

endmodule

`default_nettype wire
